[rtl/core/sim_alpha_ucs2_decoder_assert.svh]
// assertion macros for the sim alpha ucs2 decoder
// used by the top level only, no other dependencies
`ifndef SIM_ALPHA_UCS2_DECODER_ASSERT_SVH
`define SIM_ALPHA_UCS2_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define UCS2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucs2 decoder check failed");

`define UCS2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucs2 decoder check failed");

`else

`define UCS2D_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define UCS2D_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/ucs2d_pkg.sv]
// shared types, codes and gsm tables for the sim alpha ucs2 decoder
// no dependencies
package ucs2d_pkg;

    localparam logic [1:0] MODE_80  = 2'd0;
    localparam logic [1:0] MODE_81  = 2'd1;
    localparam logic [1:0] MODE_82  = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    localparam logic [1:0] PH_COUNT         = 2'd0;
    localparam logic [1:0] PH_BASE          = 2'd1;
    localparam logic [1:0] PH_AFTER_BASE    = 2'd2;
    localparam logic [1:0] PH_AFTER_BASE_LO = 2'd3;

    localparam logic [7:0]  ESC_BYTE   = 8'h1B;
    localparam logic [15:0] TERM_CODE  = 16'hFFFF;
    localparam logic [15:0] MAX_CHARS_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [1:0] coding_mode;
    } t_item;

    typedef struct packed {
        logic        emit;
        logic        char_valid;
        logic [15:0] char_code;
        logic        record_done;
        logic [15:0] char_count;
    } t_result;

    localparam logic [15:0] GSM_BASIC [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h0020, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    function automatic logic [15:0] gsm_ext(input logic [6:0] idx);
        logic [15:0] code;
        unique case (idx)
            7'h0A:   code = 16'h000A;
            7'h14:   code = 16'h005E;
            7'h1B:   code = 16'h0020;
            7'h28:   code = 16'h007B;
            7'h29:   code = 16'h007D;
            7'h2F:   code = 16'h005C;
            7'h3C:   code = 16'h005B;
            7'h3D:   code = 16'h007E;
            7'h3E:   code = 16'h005D;
            7'h40:   code = 16'h007C;
            7'h65:   code = 16'h20AC;
            default: code = 16'h0000;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/ucs2d_decode.sv]
// per-record decode state and single-pass byte decode logic
// depends on ucs2d_pkg
module ucs2d_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ucs2d_pkg::t_item    i_item,
    input  logic [15:0]         i_max_chars,
    output ucs2d_pkg::t_result  o_result
);

    logic [1:0]  r_active_mode, n_active_mode;
    logic [1:0]  r_header_phase, n_header_phase;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_base, n_base;
    logic [7:0]  r_high_hold, n_high_hold;
    logic        r_pair_half, n_pair_half;
    logic        r_escape, n_escape;
    logic [15:0] r_chars, n_chars;
    logic        r_stopped, n_stopped;

    logic        room;
    logic        char_valid;
    logic [15:0] char_code;
    logic [15:0] pair_code;
    logic [1:0]  data_phase;
    logic [7:0]  b;

    assign b          = i_item.data_byte;
    assign room       = r_chars < i_max_chars;
    assign pair_code  = {r_high_hold, b};
    assign data_phase = (r_active_mode == ucs2d_pkg::MODE_81) ?
                        ucs2d_pkg::PH_AFTER_BASE : ucs2d_pkg::PH_AFTER_BASE_LO;

    always_comb begin
        n_active_mode  = r_active_mode;
        n_header_phase = r_header_phase;
        n_bytes_left   = r_bytes_left;
        n_base         = r_base;
        n_high_hold    = r_high_hold;
        n_pair_half    = r_pair_half;
        n_escape       = r_escape;
        n_stopped      = r_stopped;
        char_valid     = 1'b0;
        char_code      = 16'h0000;

        if (i_item.first_byte) begin
            n_active_mode  = i_item.coding_mode;
            n_header_phase = ucs2d_pkg::PH_COUNT;
            n_bytes_left   = 8'd0;
            n_base         = 16'h0000;
            n_high_hold    = 8'd0;
            n_pair_half    = 1'b0;
            n_escape       = 1'b0;
            n_stopped      = (i_item.coding_mode == ucs2d_pkg::MODE_BAD);
        end else if (!r_stopped) begin
            if (r_active_mode == ucs2d_pkg::MODE_80) begin
                if (!r_pair_half) begin
                    n_high_hold = b;
                    n_pair_half = 1'b1;
                end else begin
                    n_pair_half = 1'b0;
                    if (!room || pair_code == ucs2d_pkg::TERM_CODE) begin
                        n_stopped = 1'b1;
                    end else begin
                        char_valid = 1'b1;
                        char_code  = pair_code;
                    end
                end
            end else if (r_header_phase == ucs2d_pkg::PH_COUNT) begin
                n_bytes_left   = b;
                n_header_phase = ucs2d_pkg::PH_BASE;
            end else if (r_header_phase == ucs2d_pkg::PH_BASE &&
                         r_active_mode == ucs2d_pkg::MODE_81) begin
                n_base         = {1'b0, b, 7'b0};
                n_header_phase = ucs2d_pkg::PH_AFTER_BASE;
            end else if (r_header_phase == ucs2d_pkg::PH_BASE) begin
                n_high_hold    = b;
                n_header_phase = ucs2d_pkg::PH_AFTER_BASE;
            end else if (r_header_phase == ucs2d_pkg::PH_AFTER_BASE &&
                         r_active_mode == ucs2d_pkg::MODE_82) begin
                n_base         = {r_high_hold, b};
                n_header_phase = ucs2d_pkg::PH_AFTER_BASE_LO;
            end else if (r_header_phase == data_phase) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                    if (r_bytes_left != 8'd0) begin
                        n_bytes_left = r_bytes_left - 8'd1;
                    end
                    if (room) begin
                        char_valid = 1'b1;
                        char_code  = ucs2d_pkg::gsm_ext(b[6:0]);
                    end else begin
                        n_stopped = 1'b1;
                    end
                end else if (r_bytes_left == 8'd0) begin
                    n_stopped = r_stopped;
                end else if (!room) begin
                    n_stopped = 1'b1;
                end else begin
                    n_bytes_left = r_bytes_left - 8'd1;
                    if (b[7]) begin
                        char_valid = 1'b1;
                        char_code  = r_base + {9'b0, b[6:0]};
                    end else if (b == ucs2d_pkg::ESC_BYTE) begin
                        n_escape = 1'b1;
                    end else begin
                        char_valid = 1'b1;
                        char_code  = ucs2d_pkg::GSM_BASIC[b[6:0]];
                    end
                end
            end
        end

        if (i_item.first_byte) begin
            n_chars = 16'd0;
        end else if (char_valid) begin
            n_chars = r_chars + 16'd1;
        end else begin
            n_chars = r_chars;
        end

        if (i_item.last_byte) begin
            n_stopped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_mode  <= ucs2d_pkg::MODE_80;
            r_header_phase <= ucs2d_pkg::PH_COUNT;
            r_bytes_left   <= 8'd0;
            r_base         <= 16'h0000;
            r_high_hold    <= 8'd0;
            r_pair_half    <= 1'b0;
            r_escape       <= 1'b0;
            r_chars        <= 16'd0;
            r_stopped      <= 1'b0;
        end else if (i_step) begin
            r_active_mode  <= n_active_mode;
            r_header_phase <= n_header_phase;
            r_bytes_left   <= n_bytes_left;
            r_base         <= n_base;
            r_high_hold    <= n_high_hold;
            r_pair_half    <= n_pair_half;
            r_escape       <= n_escape;
            r_chars        <= n_chars;
            r_stopped      <= n_stopped;
        end
    end

    assign o_result.emit        = char_valid | i_item.last_byte;
    assign o_result.char_valid  = char_valid;
    assign o_result.char_code   = char_code;
    assign o_result.record_done = i_item.last_byte;
    assign o_result.char_count  = n_chars;

endmodule

[rtl/core/sim_alpha_ucs2_decoder.sv]
// sim alpha record decoder top level: input register, decode, result register
// depends on ucs2d_pkg, ucs2d_decode and sim_alpha_ucs2_decoder_assert.svh
//
// input channel: one record byte per transaction with first/last markers and
// the coding mode, which is sampled on the first byte (the coding identifier).
// output channel: a result transaction is produced for each decoded character
// and for the byte marked last; other bytes give no result.
// configuration channel: writes max_chars, always ready; write only while idle.
// path: an accepted byte is held in the input register, decoded combinationally, and
// its result is registered into the result register, from which it is offered.
// throughput: one byte per cycle while the result register is free, limited by the
// single decode state update between the input register and the result register.
// reset: decode state cleared, max_chars set to 65535, no result pending,
// bytes before any first byte are decoded as mode '80' data.
// receiver stall: the result register holds, the input register still takes a byte
// if it was empty, then o_in_ready drops until the result is taken.
//
`include "sim_alpha_ucs2_decoder_assert.svh"

module sim_alpha_ucs2_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [1:0]  i_coding_mode,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_char_valid,
    output logic [15:0] o_char_code,
    output logic        o_record_done,
    output logic [15:0] o_char_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic                r_in_valid;
    ucs2d_pkg::t_item    r_item;
    logic                r_out_valid;
    ucs2d_pkg::t_result  r_out;
    logic [15:0]         r_max_chars;
    ucs2d_pkg::t_result  dec_result;
    logic                out_free;
    logic                advance;

    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= ucs2d_pkg::MAX_CHARS_RESET;
        end else if (i_cfg_valid) begin
            r_max_chars <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.data_byte   <= i_data_byte;
            r_item.first_byte  <= i_first_byte;
            r_item.last_byte   <= i_last_byte;
            r_item.coding_mode <= i_coding_mode;
        end
    end

    ucs2d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_item),
        .i_max_chars (r_max_chars),
        .o_result    (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= dec_result.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_result.emit) begin
            r_out <= dec_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_valid  = r_out.char_valid;
    assign o_char_code   = r_out.char_code;
    assign o_record_done = r_out.record_done;
    assign o_char_count  = r_out.char_count;

    `UCS2D_ASSERT_NOW(a_char_count_bounds, i_clk, i_rst_n,
        o_out_valid && o_char_valid, o_char_count != 16'd0 && o_char_count <= r_max_chars)

    `UCS2D_ASSERT_NOW(a_empty_result_is_done, i_clk, i_rst_n,
        o_out_valid && !o_char_valid, o_record_done && o_char_code == 16'h0000)

    `UCS2D_ASSERT_NEXT(a_blocked_item_kept, i_clk, i_rst_n,
        r_in_valid && !out_free, r_in_valid)

endmodule

[test/tb.sv]
// testbench for sim_alpha_ucs2_decoder: directed '80'/'81'/'82' records, capacity,
// output backpressure and random records, checked against an in-bench decoder model
// depends on ucs2d_pkg and the sim_alpha_ucs2_decoder rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int FLUSH_CYCLES = 6;
    localparam int STALL_CYCLES = 200;

    localparam logic [15:0] GSM7_UCS2 [128] = '{
        16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
        16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
        16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
        16'h03A3, 16'h0398, 16'h039E, 16'h0020, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
        16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
    };

    typedef struct packed {
        logic        valid;
        logic [15:0] code;
        logic        done;
        logic [15:0] count;
    } t_char_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic [1:0]  i_coding_mode = ucs2d_pkg::MODE_80;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic        o_char_valid;
    logic [15:0] o_char_code;
    logic        o_record_done;
    logic [15:0] o_char_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    // decoder model state
    logic [1:0]  dec_mode = ucs2d_pkg::MODE_80;
    logic [1:0]  dec_phase = ucs2d_pkg::PH_COUNT;
    logic [7:0]  dec_left = '0;
    logic [15:0] dec_base = '0;
    logic [7:0]  dec_hold = '0;
    logic        dec_half = 1'b0;
    logic        dec_esc = 1'b0;
    logic [15:0] dec_emitted = '0;
    logic        dec_stopped = 1'b0;
    logic [15:0] dec_cap = ucs2d_pkg::MAX_CHARS_RESET;

    t_char_res   pending_chars [$];
    int          mism_count = 0;
    int          bytes_sent = 0;
    int unsigned cycle_cnt = 0;
    logic        gaps_on = 1'b1;
    logic        stall_active = 1'b0;
    event        stall_go;

    sim_alpha_ucs2_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .i_coding_mode (i_coding_mode),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_valid  (o_char_valid),
        .o_char_code   (o_char_code),
        .o_record_done (o_record_done),
        .o_char_count  (o_char_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [15:0] gsm_ext_ucs2(input logic [6:0] idx);
        case (idx)
            7'h0A:   return 16'h000A;
            7'h14:   return 16'h005E;
            7'h1B:   return 16'h0020;
            7'h28:   return 16'h007B;
            7'h29:   return 16'h007D;
            7'h2F:   return 16'h005C;
            7'h3C:   return 16'h005B;
            7'h3D:   return 16'h007E;
            7'h3E:   return 16'h005D;
            7'h40:   return 16'h007C;
            7'h65:   return 16'h20AC;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic decode_byte(input ucs2d_pkg::t_item it);
        logic [7:0]  b;
        logic        vld;
        logic [15:0] code;
        logic [1:0]  data_ph;
        t_char_res   r;
        b = it.data_byte;
        vld = 1'b0;
        code = '0;
        if (it.first_byte) begin
            dec_mode = it.coding_mode;
            dec_phase = ucs2d_pkg::PH_COUNT;
            dec_left = '0;
            dec_base = '0;
            dec_hold = '0;
            dec_half = 1'b0;
            dec_esc = 1'b0;
            dec_emitted = '0;
            dec_stopped = (it.coding_mode == ucs2d_pkg::MODE_BAD);
        end else if (!dec_stopped) begin
            if (dec_mode == ucs2d_pkg::MODE_80) begin
                if (!dec_half) begin
                    dec_hold = b;
                    dec_half = 1'b1;
                end else begin
                    dec_half = 1'b0;
                    code = {dec_hold, b};
                    if (dec_emitted >= dec_cap || code == ucs2d_pkg::TERM_CODE) begin
                        dec_stopped = 1'b1;
                        code = '0;
                    end else begin
                        vld = 1'b1;
                    end
                end
            end else begin
                data_ph = (dec_mode == ucs2d_pkg::MODE_81) ? ucs2d_pkg::PH_AFTER_BASE
                                                           : ucs2d_pkg::PH_AFTER_BASE_LO;
                if (dec_phase == ucs2d_pkg::PH_COUNT) begin
                    dec_left = b;
                    dec_phase = ucs2d_pkg::PH_BASE;
                end else if (dec_phase == ucs2d_pkg::PH_BASE &&
                             dec_mode == ucs2d_pkg::MODE_81) begin
                    dec_base = {1'b0, b, 7'b0};
                    dec_phase = ucs2d_pkg::PH_AFTER_BASE;
                end else if (dec_phase == ucs2d_pkg::PH_BASE) begin
                    dec_hold = b;
                    dec_phase = ucs2d_pkg::PH_AFTER_BASE;
                end else if (dec_phase == ucs2d_pkg::PH_AFTER_BASE &&
                             dec_mode == ucs2d_pkg::MODE_82) begin
                    dec_base = {dec_hold, b};
                    dec_phase = ucs2d_pkg::PH_AFTER_BASE_LO;
                end else if (dec_phase == data_ph) begin
                    if (dec_esc) begin
                        dec_esc = 1'b0;
                        if (dec_left != 0) dec_left = dec_left - 8'd1;
                        if (dec_emitted < dec_cap) begin
                            code = gsm_ext_ucs2(b[6:0]);
                            vld = 1'b1;
                        end else begin
                            dec_stopped = 1'b1;
                        end
                    end else if (dec_left == 0) begin
                        // count used up, byte dropped
                    end else if (dec_emitted >= dec_cap) begin
                        dec_stopped = 1'b1;
                    end else begin
                        dec_left = dec_left - 8'd1;
                        if (b[7]) begin
                            code = dec_base + {9'b0, b[6:0]};
                            vld = 1'b1;
                        end else if (b == ucs2d_pkg::ESC_BYTE) begin
                            dec_esc = 1'b1;
                        end else begin
                            code = GSM7_UCS2[b[6:0]];
                            vld = 1'b1;
                        end
                    end
                end
            end
        end
        if (vld) dec_emitted = dec_emitted + 16'd1;
        if (it.last_byte) dec_stopped = 1'b1;
        if (vld || it.last_byte) begin
            r.valid = vld;
            r.code = vld ? code : 16'h0000;
            r.done = it.last_byte;
            r.count = dec_emitted;
            pending_chars.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
                             input logic [1:0] mode);
        ucs2d_pkg::t_item it;
        it.data_byte = data;
        it.first_byte = first;
        it.last_byte = last;
        it.coding_mode = mode;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(99) < 16) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_data_byte = it.data_byte;
        i_first_byte = it.first_byte;
        i_last_byte = it.last_byte;
        i_coding_mode = it.coding_mode;
        do @(posedge i_clk); while (!o_in_ready);
        decode_byte(it);
        bytes_sent++;
    endtask

    // non-first bytes carry a random mode that the block must not sample
    task automatic send_data(input logic [7:0] data, input logic last);
        send_byte(data, 1'b0, last, 2'($urandom_range(3)));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_chars(input logic [15:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        dec_cap = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (stall_active) i_out_ready = 1'b0;
        else if (gaps_on && $urandom_range(99) < 24) i_out_ready = 1'b0;
        else i_out_ready = 1'b1;
    end

    initial begin
        forever begin
            @(stall_go);
            @(posedge i_clk);
            stall_active = 1'b1;
            repeat (STALL_CYCLES) @(posedge i_clk);
            stall_active = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_char_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                mism_count++;
                if (mism_count <= 10)
                    $display("unexpected result: valid %0b code %h done %0b count %0d",
                             o_char_valid, o_char_code, o_record_done, o_char_count);
            end else begin
                want = pending_chars.pop_front();
                if (o_char_valid !== want.valid || o_char_code !== want.code ||
                    o_record_done !== want.done || o_char_count !== want.count) begin
                    mism_count++;
                    if (mism_count <= 10)
                        $display("mismatch: exp %0b %h %0b %0d, got %0b %h %0b %0d",
                                 want.valid, want.code, want.done, want.count,
                                 o_char_valid, o_char_code, o_record_done, o_char_count);
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // bytes before any first byte decode as '80' data
    task automatic test_before_first_byte();
        send_data(8'h00, 1'b0);
        send_data(8'h41, 1'b0);
    endtask

    task automatic test_mode_80();
        send_byte(8'h80, 1'b1, 1'b0, ucs2d_pkg::MODE_80);
        send_data(8'h00, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFE, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'h12, 1'b1);
        // odd trailing byte
        send_byte(8'h80, 1'b1, 1'b0, ucs2d_pkg::MODE_80);
        send_data(8'h04, 1'b0);
        send_data(8'h3A, 1'b0);
        send_data(8'h56, 1'b1);
    endtask

    task automatic test_mode_81();
        send_byte(8'h81, 1'b1, 1'b0, ucs2d_pkg::MODE_81);
        send_data(8'd3, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'h7F, 1'b0);
        send_data(ucs2d_pkg::ESC_BYTE, 1'b0);
        // escaped byte past the count, above 0x7f
        send_data(8'hE5, 1'b0);
        send_data(8'h41, 1'b1);
    endtask

    task automatic test_mode_82();
        send_byte(8'h82, 1'b1, 1'b0, ucs2d_pkg::MODE_82);
        send_data(8'd2, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hF0, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'h41, 1'b1);
        // bytes after the last byte
        send_data(8'h42, 1'b0);
        send_data(8'h43, 1'b1);
    endtask

    task automatic test_stopped_records();
        send_byte(8'h83, 1'b1, 1'b0, ucs2d_pkg::MODE_BAD);
        send_data(8'h41, 1'b1);
        send_byte(8'h81, 1'b1, 1'b0, ucs2d_pkg::MODE_81);
        send_data(8'd1, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(ucs2d_pkg::ESC_BYTE, 1'b1);
    endtask

    task automatic test_capacity();
        write_max_chars(16'd0);
        send_byte(8'h80, 1'b1, 1'b0, ucs2d_pkg::MODE_80);
        send_data(8'h00, 1'b0);
        send_data(8'h41, 1'b0);
        send_data(8'h42, 1'b1);
        write_max_chars(16'd1);
        send_byte(8'h81, 1'b1, 1'b0, ucs2d_pkg::MODE_81);
        send_data(8'd5, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'h41, 1'b0);
        send_data(8'h42, 1'b0);
        send_data(8'h43, 1'b1);
        // capacity drops to zero while an escape is pending
        write_max_chars(16'hFFFF);
        send_byte(8'h81, 1'b1, 1'b0, ucs2d_pkg::MODE_81);
        send_data(8'd3, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(ucs2d_pkg::ESC_BYTE, 1'b0);
        write_max_chars(16'd0);
        send_data(8'h65, 1'b0);
        send_data(8'h41, 1'b1);
    endtask

    function automatic logic [7:0] rand_gsm_byte();
        int r;
        r = $urandom_range(99);
        if (r < 12) return ucs2d_pkg::ESC_BYTE;
        if (r < 45) return 8'h80 | 8'($urandom_range(127));
        return 8'($urandom_range(127));
    endfunction

    task automatic send_record();
        logic [1:0] m;
        int n;
        if ($urandom_range(9) == 0) begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      2'($urandom_range(3)));
            return;
        end
        m = ($urandom_range(9) == 0) ? ucs2d_pkg::MODE_BAD : 2'($urandom_range(2));
        send_byte(8'($urandom_range(255)), 1'b1, ($urandom_range(19) == 0), m);
        if (m == ucs2d_pkg::MODE_81 || m == ucs2d_pkg::MODE_82) begin
            send_data(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(10)), 1'b0);
            send_data(8'($urandom_range(255)), 1'b0);
            if (m == ucs2d_pkg::MODE_82) send_data(8'($urandom_range(255)), 1'b0);
        end
        n = $urandom_range(12);
        if (m == ucs2d_pkg::MODE_80) n = $urandom_range(16);
        for (int i = 0; i < n; i++) begin
            if (m == ucs2d_pkg::MODE_80)
                send_data(($urandom_range(99) < 12) ? 8'hFF : 8'($urandom_range(255)), 1'b0);
            else
                send_data(rand_gsm_byte(), 1'b0);
        end
        if ($urandom_range(9) != 0)
            send_data((m == ucs2d_pkg::MODE_80) ? 8'($urandom_range(255)) : rand_gsm_byte(),
                      1'b1);
    endtask

    task automatic test_random_records();
        logic [15:0] caps [6];
        int target;
        caps = '{16'hFFFF, 16'($urandom_range(6, 1)), 16'd0, 16'd1,
                 16'($urandom_range(65535)), 16'hFFFF};
        foreach (caps[ph]) begin
            write_max_chars(caps[ph]);
            gaps_on = (ph != 4);
            target = bytes_sent + 65;
            while (bytes_sent < target) send_record();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        write_max_chars(16'hFFFF);
        -> stall_go;
        send_byte(8'h80, 1'b1, 1'b0, ucs2d_pkg::MODE_80);
        for (int i = 0; i < 40; i++) send_data(8'($urandom_range(254)), 1'b0);
        send_data(8'h20, 1'b1);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_before_first_byte();
        test_mode_80();
        test_mode_81();
        test_mode_82();
        test_stopped_records();
        test_capacity();
        test_random_records();
        test_output_backpressure();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mism_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
